[rtl/bdpq_pkg.sv]
`default_nettype none
package bdpq_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_TILE     = 64;
    localparam int PALETTE_SIZE = 4;

    localparam int COL_W   = $clog2(MAX_WIDTH);      // column / tile index
    localparam int SIZE_W  = 12;                     // width and height registers
    localparam int TILE_W  = 7;                      // tile size registers
    localparam int OFF_W   = $clog2(MAX_TILE);       // offset inside a tile
    localparam int SUM_W   = 20;
    localparam int CHAN_W  = 8;
    localparam int NCHAN   = 4;
    localparam int PAL_W   = 64;
    localparam int IDX_W   = 2;
    localparam int CNT_W   = 13;                     // tile pixel count, up to 4096
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_LOW   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_HIGH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTIZE      = 3'd7;

    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [CHAN_W-1:0] chan_t;

endpackage
`default_nettype wire

[rtl/bdpq_if.sv]
`default_nettype none
interface bdpq_pix_if;
    logic                        valid;
    logic                        ready;
    logic                        frame_start;
    logic [bdpq_pkg::CHAN_W-1:0] red_in;
    logic [bdpq_pkg::CHAN_W-1:0] green_in;
    logic [bdpq_pkg::CHAN_W-1:0] blue_in;
    logic [bdpq_pkg::CHAN_W-1:0] alpha_in;

    modport source (output valid, frame_start, red_in, green_in, blue_in, alpha_in,
                    input ready);
    modport sink   (input valid, frame_start, red_in, green_in, blue_in, alpha_in,
                    output ready);
endinterface

interface bdpq_res_if;
    logic                        valid;
    logic                        ready;
    logic [bdpq_pkg::CHAN_W-1:0] red_out;
    logic [bdpq_pkg::CHAN_W-1:0] green_out;
    logic [bdpq_pkg::CHAN_W-1:0] blue_out;
    logic [bdpq_pkg::CHAN_W-1:0] alpha_out;
    logic [bdpq_pkg::IDX_W-1:0]  palette_index;
    logic                        frame_done;

    modport source (output valid, red_out, green_out, blue_out, alpha_out,
                    palette_index, frame_done, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out,
                    palette_index, frame_done, output ready);
endinterface
`default_nettype wire

[rtl/bdpq_ram.sv]
`default_nettype none
module bdpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read on one port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

[rtl/box_downsample_palette_quantize.sv]
`default_nettype none
// Processing: each accepted pixel runs an 11-step column divide and a memory check;
//   a pixel in a covered tile is then accumulated, and one that closes a tile goes on
//   through a 20-step mean divide, 4 palette compares (skipped with quantizing off) and
//   output, where a held result makes it wait. A new pixel is taken only when idle, after
//   the last one is through. Reset: control and configuration registers go to their defaults,
//   then a clearing pass zeroes all 2048 entries of the column sum memory before the first pixel.
module box_downsample_palette_quantize (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    bdpq_pix_if.sink                               pix_in,
    bdpq_res_if.source                             res_out,
    input  wire logic                              cfg_we,
    input  wire logic [bdpq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bdpq_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int COL_W  = bdpq_pkg::COL_W;
    localparam int SIZE_W = bdpq_pkg::SIZE_W;
    localparam int TILE_W = bdpq_pkg::TILE_W;
    localparam int OFF_W  = bdpq_pkg::OFF_W;
    localparam int SUM_W  = bdpq_pkg::SUM_W;
    localparam int CHAN_W = bdpq_pkg::CHAN_W;
    localparam int NCHAN  = bdpq_pkg::NCHAN;
    localparam int CNT_W  = bdpq_pkg::CNT_W;
    localparam int IDX_W  = bdpq_pkg::IDX_W;
    localparam int RAM_W  = SUM_W * NCHAN;
    localparam int DIST_W = 2 * CHAN_W + 2;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DIVT  = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_ACC   = 4'd4;
    localparam logic [3:0] S_DIVM  = 4'd5;
    localparam logic [3:0] S_PAL   = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    // Configuration registers
    logic [SIZE_W-1:0]              src_w_reg, out_w_reg, out_h_reg;
    logic [TILE_W-1:0]              tile_w_reg, tile_h_reg;
    logic [bdpq_pkg::PAL_W-1:0]     pal_lo_reg, pal_hi_reg;
    logic                           quant_en_reg;

    // Control
    logic [3:0]          state_reg;
    logic [COL_W:0]      clr_reg;
    logic [4:0]          step_reg;
    logic [COL_W-1:0]    col_reg;
    logic [OFF_W-1:0]    row_reg;
    logic [SIZE_W-1:0]   orow_reg;
    logic                first_reg, last_reg, done_reg;

    // Payload
    bdpq_pkg::chan_t     px_reg [NCHAN];
    logic [COL_W-1:0]    dq_reg;
    logic [TILE_W-1:0]   drem_reg;
    logic [COL_W-1:0]    tile_reg;
    logic [CNT_W-1:0]    count_reg;
    bdpq_pkg::sum_t      mq_reg [NCHAN];
    logic [CNT_W-1:0]    mrem_reg [NCHAN];
    logic [IDX_W-1:0]    ent_reg, pick_reg;
    logic [DIST_W-1:0]   best_reg;

    // Output register
    logic                res_valid_reg;
    bdpq_pkg::chan_t     res_ch_reg [NCHAN];
    logic [IDX_W-1:0]    res_idx_reg;
    logic                res_done_reg;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (v > SIZE_W'(bdpq_pkg::MAX_WIDTH))
        begin
            r = SIZE_W'(bdpq_pkg::MAX_WIDTH);
        end
        return r;
    endfunction

    function automatic logic [TILE_W-1:0] clamp_tile(input logic [TILE_W-1:0] v);
        logic [TILE_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = TILE_W'(1);
        end
        else if (v > TILE_W'(bdpq_pkg::MAX_TILE))
        begin
            r = TILE_W'(bdpq_pkg::MAX_TILE);
        end
        return r;
    endfunction

    function automatic bdpq_pkg::chan_t pal_chan(input logic [IDX_W-1:0] e,
                                                 input logic [1:0] c,
                                                 input logic [63:0] lo,
                                                 input logic [63:0] hi);
        logic [63:0] word;
        logic [5:0]  sh;
        word = e[1] ? hi : lo;
        sh   = {e[0], c, 3'b000};
        return word[sh +: CHAN_W];
    endfunction

    logic [SIZE_W-1:0] sw, ow, oh;
    logic [TILE_W-1:0] tw, th;
    assign sw = clamp_size(src_w_reg);
    assign ow = clamp_size(out_w_reg);
    assign oh = clamp_size(out_h_reg);
    assign tw = clamp_tile(tile_w_reg);
    assign th = clamp_tile(tile_h_reg);

    logic pix_xfer, res_xfer;
    assign pix_in.ready = (state_reg == S_IDLE);
    assign pix_xfer     = pix_in.valid && pix_in.ready;
    assign res_xfer     = res_valid_reg && res_out.ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg    <= SIZE_W'(1);
            out_w_reg    <= SIZE_W'(1);
            out_h_reg    <= SIZE_W'(1);
            tile_w_reg   <= TILE_W'(1);
            tile_h_reg   <= TILE_W'(1);
            pal_lo_reg   <= '0;
            pal_hi_reg   <= '0;
            quant_en_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bdpq_pkg::REG_SOURCE_WIDTH:  src_w_reg    <= cfg_data[SIZE_W-1:0];
                bdpq_pkg::REG_OUTPUT_WIDTH:  out_w_reg    <= cfg_data[SIZE_W-1:0];
                bdpq_pkg::REG_OUTPUT_HEIGHT: out_h_reg    <= cfg_data[SIZE_W-1:0];
                bdpq_pkg::REG_TILE_WIDTH:    tile_w_reg   <= cfg_data[TILE_W-1:0];
                bdpq_pkg::REG_TILE_HEIGHT:   tile_h_reg   <= cfg_data[TILE_W-1:0];
                bdpq_pkg::REG_PALETTE_LOW:   pal_lo_reg   <= cfg_data;
                bdpq_pkg::REG_PALETTE_HIGH:  pal_hi_reg   <= cfg_data;
                bdpq_pkg::REG_QUANTIZE:      quant_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Column divide step
    logic [TILE_W:0]   dtrial;
    logic              dfit;
    assign dtrial = {drem_reg, dq_reg[COL_W-1]};
    assign dfit   = dtrial >= {1'b0, tw};

    // Mean divide step, four independent lanes
    logic [CNT_W:0]    mtrial [NCHAN];
    logic              mfit [NCHAN];
    always_comb
    begin
        for (int c = 0; c < NCHAN; c++)
        begin
            mtrial[c] = {mrem_reg[c], mq_reg[c][SUM_W-1]};
            mfit[c]   = mtrial[c] >= {1'b0, count_reg};
        end
    end

    // Saturated means
    bdpq_pkg::chan_t avg [NCHAN];
    always_comb
    begin
        for (int c = 0; c < NCHAN; c++)
        begin
            avg[c] = (|mq_reg[c][SUM_W-1:CHAN_W]) ? '1 : mq_reg[c][CHAN_W-1:0];
        end
    end

    // Distance to the current palette entry
    logic [DIST_W-1:0] ent_dist;
    always_comb
    begin
        bdpq_pkg::chan_t p;
        bdpq_pkg::chan_t df;
        ent_dist = '0;
        for (int c = 0; c < NCHAN; c++)
        begin
            p        = pal_chan(ent_reg, 2'(c), pal_lo_reg, pal_hi_reg);
            df       = (p > avg[c]) ? p - avg[c] : avg[c] - p;
            ent_dist = ent_dist + DIST_W'(df * df);
        end
    end

    // Memory access
    logic              ram_we;
    logic [COL_W-1:0]  ram_addr;
    logic [RAM_W-1:0]  ram_wdata, ram_rdata;
    bdpq_pkg::sum_t    new_sum [NCHAN];

    always_comb
    begin
        for (int c = 0; c < NCHAN; c++)
        begin
            new_sum[c] = first_reg ? SUM_W'(px_reg[c])
                                   : ram_rdata[c*SUM_W +: SUM_W] + SUM_W'(px_reg[c]);
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = tile_reg;
        ram_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_reg[COL_W-1:0];
            end
            S_CHECK:
            begin
                ram_addr = dq_reg;
            end
            S_ACC:
            begin
                ram_we = 1'b1;
                for (int c = 0; c < NCHAN; c++)
                begin
                    ram_wdata[c*SUM_W +: SUM_W] = new_sum[c];
                end
            end
            default: ;
        endcase
    end

    bdpq_ram #(
        .WIDTH (RAM_W),
        .DEPTH (bdpq_pkg::MAX_WIDTH)
    ) u_sums (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Position bookkeeping
    logic [SIZE_W-1:0] col_p1;
    logic [TILE_W-1:0] row_p1;
    logic              covered;
    assign col_p1  = {1'b0, col_reg} + SIZE_W'(1);
    assign row_p1  = {1'b0, row_reg} + TILE_W'(1);
    assign covered = (orow_reg < oh) && ({1'b0, dq_reg} < ow);

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            step_reg  <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            orow_reg  <= '0;
            first_reg <= 1'b0;
            last_reg  <= 1'b0;
            done_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_xfer)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (COL_W+1)'(bdpq_pkg::MAX_WIDTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (pix_xfer)
                    begin
                        if (pix_in.frame_start)
                        begin
                            col_reg  <= '0;
                            row_reg  <= '0;
                            orow_reg <= '0;
                        end
                        step_reg  <= '0;
                        state_reg <= S_DIVT;
                    end
                end
                S_DIVT:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 5'(COL_W - 1))
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    first_reg <= (row_reg == '0) && (drem_reg == '0);
                    last_reg  <= (drem_reg == tw - 1'b1) && ({1'b0, row_reg} == th - 1'b1);
                    done_reg  <= (orow_reg == oh - 1'b1) && ({1'b0, dq_reg} == ow - 1'b1);
                    // Advance column, row and band
                    if (col_p1 >= sw)
                    begin
                        col_reg <= '0;
                        if (row_p1 >= th)
                        begin
                            row_reg <= '0;
                            if (orow_reg < oh)
                            begin
                                orow_reg <= orow_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            row_reg <= row_p1[OFF_W-1:0];
                        end
                    end
                    else
                    begin
                        col_reg <= col_p1[COL_W-1:0];
                    end
                    state_reg <= covered ? S_ACC : S_IDLE;
                end
                S_ACC:
                begin
                    step_reg  <= '0;
                    state_reg <= last_reg ? S_DIVM : S_IDLE;
                end
                S_DIVM:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 5'(SUM_W - 1))
                    begin
                        state_reg <= quant_en_reg ? S_PAL : S_OUT;
                    end
                end
                S_PAL:
                begin
                    if (ent_reg == IDX_W'(bdpq_pkg::PALETTE_SIZE - 1))
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!res_valid_reg || res_out.ready)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                px_reg[0] <= pix_in.red_in;
                px_reg[1] <= pix_in.green_in;
                px_reg[2] <= pix_in.blue_in;
                px_reg[3] <= pix_in.alpha_in;
                dq_reg    <= pix_in.frame_start ? '0 : col_reg;
                drem_reg  <= '0;
            end
            S_DIVT:
            begin
                drem_reg <= dfit ? TILE_W'(dtrial - {1'b0, tw}) : dtrial[TILE_W-1:0];
                dq_reg   <= {dq_reg[COL_W-2:0], dfit};
            end
            S_CHECK:
            begin
                tile_reg <= dq_reg;
            end
            S_ACC:
            begin
                count_reg <= CNT_W'(tw * th);
                for (int c = 0; c < NCHAN; c++)
                begin
                    mq_reg[c]   <= new_sum[c];
                    mrem_reg[c] <= '0;
                end
                ent_reg  <= '0;
                pick_reg <= '0;
            end
            S_DIVM:
            begin
                for (int c = 0; c < NCHAN; c++)
                begin
                    mrem_reg[c] <= mfit[c] ? CNT_W'(mtrial[c] - {1'b0, count_reg})
                                           : mtrial[c][CNT_W-1:0];
                    mq_reg[c]   <= {mq_reg[c][SUM_W-2:0], mfit[c]};
                end
            end
            S_PAL:
            begin
                // Keep the first entry on a tie
                if (ent_reg == '0 || ent_dist < best_reg)
                begin
                    best_reg <= ent_dist;
                    pick_reg <= ent_reg;
                end
                ent_reg <= ent_reg + 1'b1;
            end
            S_OUT:
            begin
                if (!res_valid_reg || res_out.ready)
                begin
                    for (int c = 0; c < NCHAN; c++)
                    begin
                        res_ch_reg[c] <= quant_en_reg
                            ? pal_chan(pick_reg, 2'(c), pal_lo_reg, pal_hi_reg) : avg[c];
                    end
                    res_idx_reg  <= quant_en_reg ? pick_reg : '0;
                    res_done_reg <= done_reg;
                end
            end
            default: ;
        endcase
    end

    assign res_out.valid         = res_valid_reg;
    assign res_out.red_out       = res_ch_reg[0];
    assign res_out.green_out     = res_ch_reg[1];
    assign res_out.blue_out      = res_ch_reg[2];
    assign res_out.alpha_out     = res_ch_reg[3];
    assign res_out.palette_index = res_idx_reg;
    assign res_out.frame_done    = res_done_reg;

    // A pixel transfer always starts the column divide
    a_xfer_divides: assert property (@(posedge clk) disable iff (!rst_n)
        pix_xfer |=> state_reg == S_DIVT)
        else $error("pixel transfer did not start the column divide");

    // A new result comes only from the output step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

    // The sum memory is written only by the clearing pass or accumulation
    a_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_ACC))
        else $error("unexpected sum memory write");

    // A nonzero palette index needs quantizing on
    a_index_quant: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_idx_reg != '0) |-> quant_en_reg)
        else $error("palette index set with quantizing off");

endmodule
`default_nettype wire
